// ===== hw/rtl/cadj_pkg.sv =====
`default_nettype none

package cadj_pkg;

  // Register widths
  localparam int unsigned FW_BITS      = 12;
  localparam int unsigned FH_BITS      = 13;
  localparam int unsigned CFG_IDX_BITS = 1;

  // Row counter covers the frame plus the two drain rows
  localparam int unsigned ROW_BITS   = 13;
  localparam int unsigned HEIGHT_CAP = 4096;
  localparam int unsigned MIN_DIM    = 2;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 12'd1354;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd2030;

  // Word layout
  localparam int unsigned BYTE_BITS    = 8;
  localparam int unsigned IN_DATA_BITS = 3 * BYTE_BITS;
  localparam int unsigned OUT_DATA_BITS = 2 * BYTE_BITS;
  localparam int unsigned PEND_BITS    = 2 * BYTE_BITS + 1;
  localparam int unsigned LINE_BITS    = 2;

  // Mask and QA bit positions
  localparam int unsigned DET_BIT   = 0;
  localparam int unsigned CLEAR_BIT = 2;
  localparam int unsigned FLAG_BIT  = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-word control carried from the sequencer into the window stage
  typedef struct packed {
    logic                 bot;        // cloudy-or-uncertain flag of the new pixel
    logic                 row_one;    // row above is outside the frame
    logic                 row_ge1;
    logic                 row_ge2;
    logic                 col_zero;
    logic                 frame_end;  // drain word that releases the last pixel
    logic [PEND_BITS-1:0] pend;       // {determined, mask byte 1, qa byte 1}
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cloud_adjacency_window.sv =====
// Cloud adjacency window: 3x3 clear-neighborhood test over a cloud-mask raster.
// Slave stream: one word per pixel in raster order; tuser low is a pixel,
// tuser high is a flush tick. Pixel results lag by frame_width + 1 words, so
// after the last pixel the source sends frame_width + 1 flush (or any) words
// to drain the tail; a flush at frame start is swallowed without a result.
// Master stream: updated mask byte 1 and QA byte 1 of the delayed pixel;
// tlast marks the result of the frame's last pixel, after which the next word
// starts a new frame.
// Config port: index 0 frame width, index 1 frame height; a write restarts
// the frame. Write only while the block is idle.
// Throughput: one word per cycle while the master side accepts results. Each word
// reads and writes the line-flag memory and the delay-ring memory once; the
// memory reads are registered beside the stage register, and each result then in the output register.
// Reset clears counters, window and handshake state; the memories are not
// cleared and need no clearing pass, since the frame rewrites each entry
// before a result depends on it.
// When the master side stalls, one result waits in the output register and
// one more word is held in the window stage before tready drops.
`default_nettype none

module cloud_adjacency_window #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [cadj_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [cadj_pkg::FH_BITS-1:0]         cfg_data_i,
  // slave stream
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [cadj_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,  // mask_byte_zero, mask_byte_one, qa_byte_one
  input  wire logic                                 s_axis_tuser,  // cmd
  // master stream
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output      logic [cadj_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,  // mask_byte_one_out, qa_byte_one_out
  output      logic                                 m_axis_tlast   // frame_last
);

  import cadj_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);

  logic                 rd_en, restart, s1_valid, s1_go;
  logic [CW-1:0]        line_raddr, s1_col;
  logic [SW-1:0]        ring_raddr, s1_slot;
  ctl_t                 s1_ctl;
  logic                 line_we, ring_we;
  logic [LINE_BITS-1:0] line_wdata, line_rdata;
  logic [PEND_BITS-1:0] ring_wdata, ring_rdata;

  // Raster sequencer and configuration
  cadj_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_reg_e'(cfg_idx_i)),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .rd_en_o      (rd_en),
    .line_raddr_o (line_raddr),
    .ring_raddr_o (ring_raddr),
    .s1_go_i      (s1_go),
    .restart_o    (restart),
    .s1_valid_o   (s1_valid),
    .s1_ctl_o     (s1_ctl),
    .s1_col_o     (s1_col),
    .s1_slot_o    (s1_slot)
  );

  // Cloudy flags of the two rows above, one entry per column
  cadj_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_col),
    .wdata_i (line_wdata),
    .re_i    (rd_en),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Delay ring of pending pixels, frame_width + 1 slots in use
  cadj_ram #(
    .WIDTH (PEND_BITS),
    .DEPTH (MAX_WIDTH + 1)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (s1_slot),
    .wdata_i (ring_wdata),
    .re_i    (rd_en),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Window test and result register
  cadj_win u_win (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .s1_valid_i   (s1_valid),
    .s1_ctl_i     (s1_ctl),
    .s1_go_o      (s1_go),
    .line_rdata_i (line_rdata),
    .ring_rdata_i (ring_rdata),
    .line_we_o    (line_we),
    .line_wdata_o (line_wdata),
    .ring_we_o    (ring_we),
    .ring_wdata_o (ring_wdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cadj_ram.sv =====
`default_nettype none

module cadj_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cadj_seq.sv =====
`default_nettype none

module cadj_seq #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire cadj_pkg::cfg_reg_e                    cfg_idx_i,
  input  wire logic [cadj_pkg::FH_BITS-1:0]          cfg_data_i,
  // input words
  input  wire logic                                  in_valid_i,
  output      logic                                  in_ready_o,
  input  wire logic                                  in_cmd_i,
  input  wire logic [cadj_pkg::IN_DATA_BITS-1:0]     in_data_i,
  // memory read side
  output      logic                                  rd_en_o,
  output      logic [$clog2(MAX_WIDTH)-1:0]          line_raddr_o,
  output      logic [$clog2(MAX_WIDTH+1)-1:0]        ring_raddr_o,
  // window stage
  input  wire logic                                  s1_go_i,
  output      logic                                  restart_o,
  output      logic                                  s1_valid_o,
  output      cadj_pkg::ctl_t                        s1_ctl_o,
  output      logic [$clog2(MAX_WIDTH)-1:0]          s1_col_o,
  output      logic [$clog2(MAX_WIDTH+1)-1:0]        s1_slot_o
);

  import cadj_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);

  logic [FW_BITS-1:0]  fw_q;
  logic [FH_BITS-1:0]  fh_q;
  logic [EW-1:0]       eff_w;
  logic [ROW_BITS-1:0] eff_h;
  logic [ROW_BITS-1:0] row_end;

  logic [ROW_BITS-1:0] row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [SW-1:0]       slot_q, slot_d;

  logic                accept, idle_flush, take;
  logic                col_wrap, slot_wrap, data_en;
  logic [BYTE_BITS-1:0] b0, m1, q1;
  ctl_t                ctl_d;

  logic                s1_valid_q;
  ctl_t                s1_ctl_q;
  logic [CW-1:0]       s1_col_q;
  logic [SW-1:0]       s1_slot_q;

  // Frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
      endcase
    end
  end

  // Clamped frame size
  always_comb begin
    if (32'(fw_q) < MIN_DIM) begin
      eff_w = EW'(MIN_DIM);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(fw_q);
    end
    if (32'(fh_q) < MIN_DIM) begin
      eff_h = ROW_BITS'(MIN_DIM);
    end else if (32'(fh_q) > HEIGHT_CAP) begin
      eff_h = ROW_BITS'(HEIGHT_CAP);
    end else begin
      eff_h = fh_q;
    end
  end

  assign row_end = eff_h + ROW_BITS'(1);

  // Handshake
  assign in_ready_o = ~s1_valid_q | s1_go_i;
  assign accept     = in_valid_i & in_ready_o;
  assign idle_flush = in_cmd_i & (row_q == '0) & (col_q == '0);
  assign take       = accept & ~idle_flush;
  assign restart_o  = cfg_we_i;

  assign col_wrap  = ({1'b0, col_q} + EW'(1)) == eff_w;
  assign slot_wrap = 32'(slot_q) == 32'(eff_w);

  // Raster position and delay-ring slot
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (cfg_we_i) begin
      row_d  = '0;
      col_d  = '0;
      slot_d = '0;
    end else if (take) begin
      if (row_q == row_end) begin
        row_d  = '0;
        col_d  = '0;
        slot_d = '0;
      end else begin
        if (col_wrap) begin
          col_d = '0;
          row_d = row_q + ROW_BITS'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
        slot_d = slot_wrap ? '0 : slot_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  // Pixel data; flush words and drain rows count as zero
  assign data_en = ~in_cmd_i & (row_q < eff_h);
  assign b0 = data_en ? in_data_i[BYTE_BITS-1:0]             : '0;
  assign m1 = data_en ? in_data_i[2*BYTE_BITS-1:BYTE_BITS]   : '0;
  assign q1 = data_en ? in_data_i[3*BYTE_BITS-1:2*BYTE_BITS] : '0;

  always_comb begin
    ctl_d.bot       = b0[DET_BIT] & ~b0[CLEAR_BIT];
    ctl_d.row_one   = row_q == ROW_BITS'(1);
    ctl_d.row_ge1   = row_q != '0;
    ctl_d.row_ge2   = row_q >= ROW_BITS'(2);
    ctl_d.col_zero  = col_q == '0;
    ctl_d.frame_end = row_q == row_end;
    ctl_d.pend      = {b0[DET_BIT], m1, q1};
  end

  // Memory read issue
  assign rd_en_o      = take;
  assign line_raddr_o = col_q;
  assign ring_raddr_o = slot_q;

  // Stage register in front of the window logic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctl_q  <= ctl_d;
      s1_col_q  <= col_q;
      s1_slot_q <= slot_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_ctl_o   = s1_ctl_q;
  assign s1_col_o   = s1_col_q;
  assign s1_slot_o  = s1_slot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cadj_win.sv =====
`default_nettype none

module cadj_win (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                restart_i,
  // stage from the sequencer
  input  wire logic                                s1_valid_i,
  input  wire cadj_pkg::ctl_t                      s1_ctl_i,
  output      logic                                s1_go_o,
  // memory data
  input  wire logic [cadj_pkg::LINE_BITS-1:0]      line_rdata_i,
  input  wire logic [cadj_pkg::PEND_BITS-1:0]      ring_rdata_i,
  output      logic                                line_we_o,
  output      logic [cadj_pkg::LINE_BITS-1:0]      line_wdata_o,
  output      logic                                ring_we_o,
  output      logic [cadj_pkg::PEND_BITS-1:0]      ring_wdata_o,
  // result words
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic [cadj_pkg::OUT_DATA_BITS-1:0]  out_data_o,
  output      logic                                out_last_o
);

  import cadj_pkg::*;

  localparam int unsigned COL_BITS = 3;
  localparam int unsigned WIN_BITS = COL_BITS * COL_BITS;
  localparam logic [BYTE_BITS-1:0] FLAG_MASK = BYTE_BITS'(1) << FLAG_BIT;

  logic [WIN_BITS-1:0]  win_q, win_d, win_eval;
  logic [COL_BITS-1:0]  triple;
  logic                 top, mid, emit, out_free, go, det, clear_win;
  logic [BYTE_BITS-1:0] m1_res, q1_res;

  logic                     out_valid_q;
  logic [OUT_DATA_BITS-1:0] out_data_q;
  logic                     out_last_q;

  // Column of flags: rows r-2, r-1, r; the row above line 0 is clear
  assign top    = line_rdata_i[1] & ~s1_ctl_i.row_one;
  assign mid    = line_rdata_i[0];
  assign triple = {s1_ctl_i.bot, mid, top};

  // Window around the delayed pixel; a new line clips the right edge
  assign win_eval = s1_ctl_i.col_zero ? {{COL_BITS{1'b0}}, win_q[WIN_BITS-1:COL_BITS]}
                                      : {triple, win_q[WIN_BITS-1:COL_BITS]};
  assign win_d    = s1_ctl_i.col_zero ? {triple, {(WIN_BITS-COL_BITS){1'b0}}} : win_eval;
  assign emit     = s1_ctl_i.col_zero ? s1_ctl_i.row_ge2 : s1_ctl_i.row_ge1;

  assign out_free = ~out_valid_q | out_ready_i;
  assign go       = s1_valid_i & (~emit | out_free);
  assign s1_go_o  = go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart_i) begin
      win_q <= '0;
    end else if (go) begin
      win_q <= win_d;
    end
  end

  // Line buffer keeps {row r-1, row r}; ring takes the new pixel
  assign line_we_o    = go;
  assign line_wdata_o = {mid, s1_ctl_i.bot};
  assign ring_we_o    = go;
  assign ring_wdata_o = s1_ctl_i.pend;

  // Update of the delayed pixel
  assign det       = ring_rdata_i[PEND_BITS-1];
  assign clear_win = win_eval == '0;
  assign m1_res = ring_rdata_i[2*BYTE_BITS-1:BYTE_BITS] | ((det & clear_win) ? FLAG_MASK : '0);
  assign q1_res = ring_rdata_i[BYTE_BITS-1:0] | (det ? FLAG_MASK : '0);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_data_q <= {q1_res, m1_res};
      out_last_q <= s1_ctl_i.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
